FILE: hdl/sdpwm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the sigma-delta PWM modulator.
package sdpwm_pkg;

   // Request command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Configuration port
   localparam int CSR_IDX_W = 2;
   localparam int REG_W     = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 2'd3;

   // Register reset values
   localparam logic [REG_W-1:0] TICKS_RESET = 16'd20;
   localparam logic [REG_W-1:0] TOP_RESET   = 16'd89;
   localparam logic [REG_W-1:0] GAIN_UNITY  = 16'h8000;

   // Depth of the internal queues (power of two)
   localparam int FIFO_DEPTH = 2;

   // Request class decided by the front end
   localparam int KIND_W = 2;
   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH     = 2'd0,
      KIND_TICK_OFF = 2'd1,
      KIND_TICK_RUN = 2'd2
   } item_kind_type;

   // Configuration seen by the back end
   typedef struct packed {
      logic [REG_W-1:0] ticks_per_sample;
      logic [REG_W-1:0] top_count;
      logic [REG_W-1:0] gain;
   } cfg_type;

endpackage

FILE: hdl/sdpwm_fifo.sv
`timescale 1ns / 1ps
// Small first-in first-out queue with full and empty flags.
module sdpwm_fifo #(
   parameter int WIDTH = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = $clog2(sdpwm_pkg::FIFO_DEPTH);
   localparam int CNT_W = $clog2(sdpwm_pkg::FIFO_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [sdpwm_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(sdpwm_pkg::FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: hdl/sdpwm_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, classifies them and queues them for the back end.
module sdpwm_front #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   input  logic                             req_cmd,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_sample_in,
   output logic                             req_full,
   input  logic                             enable,
   input  logic                             cmd_pop,
   output logic                             cmd_empty,
   output sdpwm_pkg::item_kind_type         cmd_kind,
   output logic signed [SAMPLE_WIDTH-1:0]   cmd_sample
);

   localparam int ENTRY_W = sdpwm_pkg::KIND_W + SAMPLE_WIDTH;

   sdpwm_pkg::item_kind_type kind_in;
   logic [ENTRY_W-1:0]       entry_in;
   logic [ENTRY_W-1:0]       entry_out;

   // Classify the request: a tick's fate depends on whether the modulator runs
   always_comb begin
      if (req_cmd == sdpwm_pkg::CMD_PUSH) begin
         kind_in = sdpwm_pkg::KIND_PUSH;
      end else if (enable) begin
         kind_in = sdpwm_pkg::KIND_TICK_RUN;
      end else begin
         kind_in = sdpwm_pkg::KIND_TICK_OFF;
      end
   end

   assign entry_in = {kind_in, req_sample_in};

   // Hold classified requests until the back end takes them
   sdpwm_fifo #(
      .WIDTH (ENTRY_W)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (entry_in),
      .full  (req_full),
      .pop   (cmd_pop),
      .rdata (entry_out),
      .empty (cmd_empty)
   );

   assign cmd_kind   = sdpwm_pkg::item_kind_type'(entry_out[ENTRY_W-1:SAMPLE_WIDTH]);
   assign cmd_sample = signed'(entry_out[SAMPLE_WIDTH-1:0]);

endmodule

FILE: hdl/sdpwm_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
module sdpwm_div #(
   parameter int DW = 32,
   parameter int VW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic [VW-1:0] remainder
);

   localparam int CW = $clog2(DW + 1);

   logic [VW-1:0] rem_ff;
   logic [VW-1:0] dvs_ff;
   logic [DW-1:0] quo_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [VW:0]   trial;
   logic [VW:0]   diff;
   logic          ge;

   // Shift the next dividend bit into the partial remainder and try a subtract
   assign trial = {rem_ff, quo_ff[DW-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = (trial >= {1'b0, dvs_ff});

   // Sequence control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[VW-1:0] : trial[VW-1:0];
         quo_ff <= {quo_ff[DW-2:0], ge};
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: hdl/sdpwm_back.sv
`timescale 1ns / 1ps
// Back end: sample store, interpolation, scaling and the sigma-delta loop.
module sdpwm_back #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sdpwm_pkg::cfg_type              cfg,
   input  logic                            phase_clr,
   input  logic                            cmd_empty,
   input  sdpwm_pkg::item_kind_type        cmd_kind,
   input  logic signed [SAMPLE_WIDTH-1:0]  cmd_sample,
   output logic                            cmd_pop,
   input  logic                            rsp_full,
   output logic                            rsp_push,
   output logic [sdpwm_pkg::REG_W-1:0]     rsp_duty,
   output logic                            rsp_out_bit
);

   localparam int W   = SAMPLE_WIDTH;
   localparam int RW  = sdpwm_pkg::REG_W;
   localparam int DW  = W + RW;       // magnitude of (s1-s0)*p
   localparam int P1W = W + RW + 2;   // signed (W+1) x (RW+1) product
   localparam int P2W = W + RW + 1;   // signed W x (RW+1) product
   localparam int EW  = W + 2;        // error and level width
   localparam logic signed [EW-1:0] HALF = EW'(2 ** (W - 1));
   localparam logic signed [EW-1:0] ONE  = EW'(2 ** W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD_WAIT,
      ST_MUL1,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_MUL2,
      ST_FIN,
      ST_EMIT
   } state_type;

   state_type                state_ff;
   logic signed [W-1:0]      slot_ff [2];
   logic                     ptr_ff;
   logic [RW-1:0]            phase_ff;
   logic signed [EW-1:0]     err_ff;
   logic [RW-1:0]            p_ff;
   logic signed [P1W-1:0]    prod1_ff;
   logic                     neg_ff;
   logic signed [W-1:0]      interp_ff;
   logic signed [P2W-1:0]    prod2_ff;
   logic [RW-1:0]            duty_ff;
   logic                     bit_ff;
   logic                     div_start_ff;
   logic [DW-1:0]            dividend_ff;

   logic [RW-1:0]            tdiv;
   logic [RW-1:0]            gsat;
   logic [RW-1:0]            top_eff;
   logic                     div_done;
   logic [DW-1:0]            div_quo;
   logic [RW-1:0]            div_rem;
   logic signed [W:0]        diff_in;
   logic signed [P1W-1:0]    prod1_in;
   logic signed [P1W-1:0]    mag1_in;
   logic signed [W:0]        qs_in;
   logic signed [W:0]        interp_in;
   logic signed [P2W-1:0]    prod2_in;
   logic signed [W-1:0]      amp_in;
   logic signed [EW-1:0]     temp_in;
   logic                     bit_in;
   logic signed [EW-1:0]     err_in;
   logic [RW:0]              pnext_in;
   logic [RW-1:0]            phase_in;

   // Clamp the register values that have illegal codes
   assign tdiv    = (cfg.ticks_per_sample == '0) ? RW'(1) : cfg.ticks_per_sample;
   assign gsat    = (cfg.gain > sdpwm_pkg::GAIN_UNITY) ? sdpwm_pkg::GAIN_UNITY : cfg.gain;
   assign top_eff = (cfg.top_count == '0) ? RW'(1) : cfg.top_count;

   // Interpolation slope times phase
   assign diff_in  = {slot_ff[1][W-1], slot_ff[1]} - {slot_ff[0][W-1], slot_ff[0]};
   assign prod1_in = P1W'(diff_in * signed'({1'b0, p_ff}));
   assign mag1_in  = (prod1_ff < 0) ? -prod1_ff : prod1_ff;

   // Quotient truncates toward zero: apply the sign after the unsigned divide
   assign qs_in     = neg_ff ? -signed'({1'b0, div_quo[W-1:0]})
                             : signed'({1'b0, div_quo[W-1:0]});
   assign interp_in = {slot_ff[0][W-1], slot_ff[0]} + qs_in;

   // Volume scaling, floored by the arithmetic shift
   assign prod2_in = P2W'(interp_ff * signed'({1'b0, gsat}));
   assign amp_in   = prod2_ff[W+14:15];

   // Sigma-delta loop: map to [0,1), add the error, compare against one half
   assign temp_in = {{2{amp_in[W-1]}}, amp_in} + HALF + err_ff;
   assign bit_in  = (temp_in > HALF);
   assign err_in  = bit_in ? temp_in - ONE : temp_in;

   // Phase advance, wrapping at the divisor
   assign pnext_in = {1'b0, p_ff} + 1'b1;
   assign phase_in = (pnext_in >= {1'b0, tdiv}) ? '0 : pnext_in[RW-1:0];

   assign cmd_pop     = (state_ff == ST_IDLE) && !cmd_empty;
   assign rsp_push    = (state_ff == ST_EMIT) && !rsp_full;
   assign rsp_duty    = duty_ff;
   assign rsp_out_bit = bit_ff;

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff[0]   <= '0;
         slot_ff[1]   <= '0;
         ptr_ff       <= 1'b0;
         phase_ff     <= '0;
         err_ff       <= '0;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (phase_clr) begin
            phase_ff <= '0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!cmd_empty) begin
                  unique case (cmd_kind)
                     sdpwm_pkg::KIND_PUSH: begin
                        slot_ff[ptr_ff] <= cmd_sample;
                        ptr_ff          <= !ptr_ff;
                     end
                     sdpwm_pkg::KIND_TICK_OFF: begin
                        duty_ff  <= '0;
                        bit_ff   <= 1'b0;
                        state_ff <= ST_EMIT;
                     end
                     sdpwm_pkg::KIND_TICK_RUN: begin
                        // Reduce the phase modulo the divisor first
                        dividend_ff  <= {{(DW-RW){1'b0}}, phase_ff};
                        div_start_ff <= 1'b1;
                        state_ff     <= ST_MOD_WAIT;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_MOD_WAIT: begin
               if (div_done) begin
                  p_ff     <= div_rem;
                  state_ff <= ST_MUL1;
               end
            end
            ST_MUL1: begin
               prod1_ff <= prod1_in;
               state_ff <= ST_DIV_GO;
            end
            ST_DIV_GO: begin
               neg_ff       <= (prod1_ff < 0);
               dividend_ff  <= mag1_in[DW-1:0];
               div_start_ff <= 1'b1;
               state_ff     <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  interp_ff <= interp_in[W-1:0];
                  state_ff  <= ST_MUL2;
               end
            end
            ST_MUL2: begin
               prod2_ff <= prod2_in;
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               err_ff   <= err_in;
               bit_ff   <= bit_in;
               duty_ff  <= bit_in ? top_eff : '0;
               phase_ff <= phase_in;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!rsp_full) begin
                  state_ff <= ST_IDLE;
               end
            end
         endcase
      end
   end

   // Shared divider for the phase reduction and the interpolation quotient
   sdpwm_div #(
      .DW (DW),
      .VW (RW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (dividend_ff),
      .divisor   (tdiv),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

endmodule

FILE: hdl/sigma_delta_pwm_modulator.sv
`timescale 1ns / 1ps
// Top level of the first-order sigma-delta PWM modulator.
//
// Requests enter through a two-deep queue (req_push/req_full) and results leave
// through another (rsp_empty/rsp_pop), so either side may stall on its own. For
// a tick while enabled the back end runs one restoring divider, one bit per
// cycle, twice per tick - once to reduce the phase modulo ticks_per_sample and
// once for the interpolation quotient - with two registered multiplies around
// it. Ticks yield exactly one result (duty, out_bit); pushes yield none.
// Registers are written through csr_we/csr_index/csr_wdata; the user must write
// them only while the block is idle, which the block itself does not enforce.
// Writing one to enable clears the phase counter, unless the back end advances
// the phase in the same cycle, but never the error accumulator.
module sigma_delta_pwm_modulator #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic                                 req_cmd,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_sample_in,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [sdpwm_pkg::REG_W-1:0]          rsp_duty,
   output logic                                 rsp_out_bit,
   input  logic                                 csr_we,
   input  logic [sdpwm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sdpwm_pkg::REG_W-1:0]          csr_wdata
);

   localparam int RSP_W = sdpwm_pkg::REG_W + 1;

   logic                              enable_ff;
   sdpwm_pkg::cfg_type                cfg_ff;
   logic                              phase_clr;
   logic                              cmd_pop;
   logic                              cmd_empty;
   sdpwm_pkg::item_kind_type          cmd_kind;
   logic signed [SAMPLE_WIDTH-1:0]    cmd_sample;
   logic                              rsp_full;
   logic                              rsp_push;
   logic [sdpwm_pkg::REG_W-1:0]       back_duty;
   logic                              back_bit;
   logic [RSP_W-1:0]                  rsp_entry;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff               <= 1'b0;
         cfg_ff.ticks_per_sample <= sdpwm_pkg::TICKS_RESET;
         cfg_ff.top_count        <= sdpwm_pkg::TOP_RESET;
         cfg_ff.gain             <= sdpwm_pkg::GAIN_UNITY;
      end else if (csr_we) begin
         unique case (csr_index)
            sdpwm_pkg::CSR_ENABLE: enable_ff               <= csr_wdata[0];
            sdpwm_pkg::CSR_TICKS:  cfg_ff.ticks_per_sample <= csr_wdata;
            sdpwm_pkg::CSR_TOP:    cfg_ff.top_count        <= csr_wdata;
            sdpwm_pkg::CSR_GAIN:   cfg_ff.gain             <= csr_wdata;
         endcase
      end
   end

   // A write of one to enable restarts the phase, unless the back end advances it in the same cycle
   assign phase_clr = csr_we && (csr_index == sdpwm_pkg::CSR_ENABLE) && csr_wdata[0];

   sdpwm_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_cmd       (req_cmd),
      .req_sample_in (req_sample_in),
      .req_full      (req_full),
      .enable        (enable_ff),
      .cmd_pop       (cmd_pop),
      .cmd_empty     (cmd_empty),
      .cmd_kind      (cmd_kind),
      .cmd_sample    (cmd_sample)
   );

   sdpwm_back #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .phase_clr   (phase_clr),
      .cmd_empty   (cmd_empty),
      .cmd_kind    (cmd_kind),
      .cmd_sample  (cmd_sample),
      .cmd_pop     (cmd_pop),
      .rsp_full    (rsp_full),
      .rsp_push    (rsp_push),
      .rsp_duty    (back_duty),
      .rsp_out_bit (back_bit)
   );

   // Result queue
   sdpwm_fifo #(
      .WIDTH (RSP_W)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata ({back_duty, back_bit}),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_entry),
      .empty (rsp_empty)
   );

   assign rsp_duty    = rsp_entry[RSP_W-1:1];
   assign rsp_out_bit = rsp_entry[0];

endmodule

FILE: hdl/sdpwm_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the sigma-delta PWM modulator and their binding.
module sdpwm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_full,
   input logic                        rsp_empty,
   input logic                        rsp_pop,
   input logic [sdpwm_pkg::REG_W-1:0] rsp_duty,
   input logic                        rsp_out_bit
);

   // Both queues come out of reset drained
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not drained after reset");

   // A zero bit always drives a zero duty
   a_zero_duty: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_out_bit) |-> (rsp_duty == '0))
      else $error("nonzero duty with a zero output bit");

   // A one bit always drives a nonzero duty, since the period is at least one
   a_one_duty: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_out_bit) |-> (rsp_duty != '0))
      else $error("zero duty with a one output bit");

   // A waiting result stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_duty) && $stable(rsp_out_bit)))
      else $error("waiting result changed before it was taken");

endmodule

bind sigma_delta_pwm_modulator sdpwm_checker u_sdpwm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_full    (req_full),
   .rsp_empty   (rsp_empty),
   .rsp_pop     (rsp_pop),
   .rsp_duty    (rsp_duty),
   .rsp_out_bit (rsp_out_bit)
);
